### design/gha_pkg.sv
// Shared types, constants and helpers for the generational handle allocator.
// No dependencies; every other design file refers to this package by scope.
package gha_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int GEN_BITS  = 16;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int GEN_W     = GEN_BITS;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_DESTROY  = 2'd1,
        OP_VALIDATE = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIFO_RD,
        ST_EXEC
    } t_state;

    // Classified request as it sits in the request queue.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] gen;
        logic             gen_nz;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] gen;
        logic [CNT_W-1:0] live;
    } t_rsp;

    typedef struct packed {
        logic             alive;
        logic [GEN_W-1:0] gen;
    } t_slot;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(MAX_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### design/generational_handle_allocator_core.sv
// Top level of the generational handle allocator: request front end,
// execution back end and result queue. Uses gha_pkg, gha_front, gha_back, gha_out.
//
//  Channel   | Handshake          | Transfer when      | Payload
//  ----------+--------------------+--------------------+-------------------------------
//  request   | push in, full out  | push && !full      | req_type, handle_index/gen
//  result    | pop in, empty out  | pop && !empty      | status, out_index/gen, live_count
//
// Sequencing: a request goes from idle to the execute state. The back-end
// sequencer waits there on the registered read of the slot table, and a
// reused create first waits on the registered read of the free-index ring.
// Reset: synchronous, active low; clears sequencer state, counters and queue
// pointers only. The slot table and free ring are not swept: no startup pass.
// Stalls: full rises when two requests wait; the back end holds while the
// result queue is full, so a stalled result side backs up into the request queue.
module generational_handle_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [9:0]  i_handle_index,
    input  logic [15:0] i_handle_generation,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [9:0]  o_out_index,
    output logic [15:0] o_out_generation,
    output logic [10:0] o_live_count
);

    gha_pkg::t_req req;
    logic          req_valid, req_pop;
    gha_pkg::t_rsp rsp_in, rsp_out;
    logic          rsp_push, rsp_ready;

    // Accept and classify requests.
    gha_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .o_full              (full),
        .i_req_type          (i_req_type),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_req_valid         (req_valid),
        .o_req               (req),
        .i_req_pop           (req_pop)
    );

    // Execute one request at a time against the tables.
    gha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_pop   (req_pop),
        .i_rsp_ready (rsp_ready),
        .o_rsp_push  (rsp_push),
        .o_rsp       (rsp_in)
    );

    // Hold results until the consumer pops them.
    gha_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rsp_push  (rsp_push),
        .i_rsp       (rsp_in),
        .o_rsp_ready (rsp_ready),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_rsp       (rsp_out)
    );

    assign o_status         = rsp_out.status;
    assign o_out_index      = rsp_out.index;
    assign o_out_generation = rsp_out.gen;
    assign o_live_count     = rsp_out.live;

endmodule

### design/gha_front.sv
// Front end: accepts requests on the push/full side, classifies them and
// holds them in a two-entry queue for the back end. Uses gha_pkg.
module gha_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [1:0]                i_req_type,
    input  logic [gha_pkg::IDX_W-1:0] i_handle_index,
    input  logic [gha_pkg::GEN_W-1:0] i_handle_generation,
    output logic                      o_req_valid,
    output gha_pkg::t_req             o_req,
    input  logic                      i_req_pop
);

    gha_pkg::t_req r_q [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_cnt;
    logic          n_wr_ptr, n_rd_ptr;
    logic [1:0]    n_cnt;
    logic          push_ok, pop_ok;
    gha_pkg::t_req cls;

    // Classify: decode the opcode and flag the null generation up front.
    always_comb begin
        cls.op     = gha_pkg::t_op'(i_req_type);
        cls.index  = i_handle_index;
        cls.gen    = i_handle_generation;
        cls.gen_nz = (i_handle_generation != '0);
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rd_ptr];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_req_pop && o_req_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push_ok;
        n_rd_ptr = r_rd_ptr ^ pop_ok;
        n_cnt    = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

### design/gha_back.sv
// Back end: sequencer that executes one request at a time against the slot
// table and the free-index ring, and hands one result per request onward.
// Uses gha_pkg.
module gha_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  gha_pkg::t_req i_req,
    output logic          o_req_pop,
    input  logic          i_rsp_ready,
    output logic          o_rsp_push,
    output gha_pkg::t_rsp o_rsp
);

    gha_pkg::t_slot            m_slot [gha_pkg::MAX_SLOTS];
    logic [gha_pkg::IDX_W-1:0] m_free [gha_pkg::MAX_SLOTS];

    gha_pkg::t_state           r_state, n_state;
    gha_pkg::t_req             r_req;
    logic [gha_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_from_free, r_fresh;
    gha_pkg::t_slot            r_slot_rd;
    logic [gha_pkg::IDX_W-1:0] r_free_rd;

    logic [gha_pkg::CNT_W-1:0] r_slots_used, n_slots_used;
    logic [gha_pkg::IDX_W-1:0] r_free_head, n_free_head;
    logic [gha_pkg::IDX_W-1:0] r_free_tail, n_free_tail;
    logic [gha_pkg::CNT_W-1:0] r_free_count, n_free_count;
    logic [gha_pkg::CNT_W-1:0] r_alive_total, n_alive_total;

    logic                      slot_rd_en, free_rd_en, slot_we, free_we;
    logic [gha_pkg::IDX_W-1:0] slot_rd_addr;
    gha_pkg::t_slot            slot_wdata;

    logic                      free_nz, has_room;
    logic                      cur_alive;
    logic [gha_pkg::GEN_W-1:0] cur_gen, lift_gen;
    logic                      handle_hit;

    assign free_nz  = (r_free_count != '0);
    assign has_room = (r_slots_used < gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS));

    // A fresh slot reads as not alive with generation zero.
    assign cur_alive  = r_fresh ? 1'b0 : r_slot_rd.alive;
    assign cur_gen    = r_fresh ? '0 : r_slot_rd.gen;
    assign lift_gen   = (cur_gen == '0) ? gha_pkg::GEN_W'(1) : cur_gen;
    assign handle_hit = r_req.gen_nz
                        && (gha_pkg::CNT_W'(r_req.index) < r_slots_used)
                        && r_slot_rd.alive
                        && (r_slot_rd.gen == r_req.gen);

    always_comb begin
        n_state = r_state;
        case (r_state)
            gha_pkg::ST_IDLE: begin
                if (o_req_pop) begin
                    n_state = (i_req.op == gha_pkg::OP_CREATE && free_nz)
                              ? gha_pkg::ST_FIFO_RD : gha_pkg::ST_EXEC;
                end
            end
            gha_pkg::ST_FIFO_RD: n_state = gha_pkg::ST_EXEC;
            gha_pkg::ST_EXEC:    n_state = gha_pkg::ST_IDLE;
            default:             n_state = gha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_pop     = 1'b0;
        slot_rd_en    = 1'b0;
        free_rd_en    = 1'b0;
        slot_rd_addr  = i_req.index;
        slot_we       = 1'b0;
        slot_wdata    = '0;
        free_we       = 1'b0;
        n_idx         = r_idx;
        n_slots_used  = r_slots_used;
        n_free_head   = r_free_head;
        n_free_tail   = r_free_tail;
        n_free_count  = r_free_count;
        n_alive_total = r_alive_total;
        o_rsp_push    = 1'b0;
        o_rsp.status  = gha_pkg::STATUS_OK;
        o_rsp.index   = '0;
        o_rsp.gen     = '0;
        o_rsp.live    = r_alive_total;
        case (r_state)
            gha_pkg::ST_IDLE: begin
                if (i_req_valid && i_rsp_ready) begin
                    o_req_pop = 1'b1;
                    n_idx     = i_req.index;
                    if (i_req.op == gha_pkg::OP_CREATE) begin
                        if (free_nz) begin
                            free_rd_en = 1'b1;
                        end else begin
                            n_idx = r_slots_used[gha_pkg::IDX_W-1:0];
                        end
                    end else if (i_req.op == gha_pkg::OP_DESTROY
                                 || i_req.op == gha_pkg::OP_VALIDATE) begin
                        slot_rd_en = 1'b1;
                    end
                end
            end
            gha_pkg::ST_FIFO_RD: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = r_free_rd;
                n_idx        = r_free_rd;
            end
            gha_pkg::ST_EXEC: begin
                o_rsp_push = 1'b1;
                case (r_req.op)
                    gha_pkg::OP_CREATE: begin
                        if (r_from_free || r_fresh) begin
                            slot_we          = 1'b1;
                            slot_wdata.alive = 1'b1;
                            slot_wdata.gen   = lift_gen;
                            n_alive_total    = r_alive_total
                                               + gha_pkg::CNT_W'(!cur_alive);
                            if (r_from_free) begin
                                n_free_head  = gha_pkg::ring_next(r_free_head);
                                n_free_count = r_free_count - 1'b1;
                            end else begin
                                n_slots_used = r_slots_used + 1'b1;
                            end
                            o_rsp.index = r_idx;
                            o_rsp.gen   = lift_gen;
                            o_rsp.live  = n_alive_total;
                        end else begin
                            o_rsp.status = gha_pkg::STATUS_FULL;
                        end
                    end
                    gha_pkg::OP_DESTROY: begin
                        if (handle_hit) begin
                            slot_we          = 1'b1;
                            slot_wdata.alive = 1'b0;
                            slot_wdata.gen   = r_slot_rd.gen + 1'b1;
                            if (r_alive_total != '0) begin
                                n_alive_total = r_alive_total - 1'b1;
                            end
                            if (r_free_count
                                < gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS)) begin
                                free_we      = 1'b1;
                                n_free_tail  = gha_pkg::ring_next(r_free_tail);
                                n_free_count = r_free_count + 1'b1;
                            end
                            o_rsp.live = n_alive_total;
                        end else begin
                            o_rsp.status = gha_pkg::STATUS_INVALID;
                        end
                    end
                    gha_pkg::OP_VALIDATE: begin
                        o_rsp.status = handle_hit ? gha_pkg::STATUS_OK
                                                  : gha_pkg::STATUS_INVALID;
                    end
                    gha_pkg::OP_CLEAR: begin
                        n_slots_used  = '0;
                        n_free_head   = '0;
                        n_free_tail   = '0;
                        n_free_count  = '0;
                        n_alive_total = '0;
                        o_rsp.live    = '0;
                    end
                    default: begin
                        o_rsp.status = gha_pkg::STATUS_OK;
                    end
                endcase
            end
            default: begin
                o_rsp_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gha_pkg::ST_IDLE;
            r_slots_used  <= '0;
            r_free_head   <= '0;
            r_free_tail   <= '0;
            r_free_count  <= '0;
            r_alive_total <= '0;
        end else begin
            r_state       <= n_state;
            r_slots_used  <= n_slots_used;
            r_free_head   <= n_free_head;
            r_free_tail   <= n_free_tail;
            r_free_count  <= n_free_count;
            r_alive_total <= n_alive_total;
        end
    end

    // Captured request and the source of the slot it will use.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_req_pop) begin
            r_req       <= i_req;
            r_from_free <= free_nz;
            r_fresh     <= !free_nz && has_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            m_slot[r_idx] <= slot_wdata;
        end
        if (slot_rd_en) begin
            r_slot_rd <= m_slot[slot_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            m_free[r_free_tail] <= r_idx;
        end
        if (free_rd_en) begin
            r_free_rd <= m_free[r_free_head];
        end
    end

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_pop |=> r_state != gha_pkg::ST_IDLE)
        else $error("request taken but sequencer stayed idle");

    a_push_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_push |=> r_state == gha_pkg::ST_IDLE)
        else $error("result sent but sequencer did not return to idle");

    a_alive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive_total <= r_slots_used)
        else $error("live count exceeds slots in use");

    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_alive_total} + {1'b0, r_free_count}) <= {1'b0, r_slots_used})
        else $error("alive plus free slots exceed slots in use");

endmodule

### design/gha_out.sv
// Result queue: two-entry buffer between the back end and the
// empty/pop side of the block. Uses gha_pkg.
module gha_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rsp_push,
    input  gha_pkg::t_rsp i_rsp,
    output logic          o_rsp_ready,
    output logic          o_empty,
    input  logic          i_pop,
    output gha_pkg::t_rsp o_rsp
);

    gha_pkg::t_rsp r_q [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_cnt;
    logic          push_ok, pop_ok;

    assign o_rsp_ready = (r_cnt != 2'd2);
    assign o_empty     = (r_cnt == 2'd0);
    assign o_rsp       = r_q[r_rd_ptr];
    assign push_ok     = i_rsp_push && o_rsp_ready;
    assign pop_ok      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr ^ push_ok;
            r_rd_ptr <= r_rd_ptr ^ pop_ok;
            r_cnt    <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= i_rsp;
        end
    end

endmodule

### sim/generational_handle_allocator_core_tb.sv
// Self-checking testbench for generational_handle_allocator_core: checks every result
// against a cycle-free predictor of the slot table, free-index ring and live count.
// Depends on gha_pkg and the design top level only.
module generational_handle_allocator_core_tb;

    // Stop the run here if transfers stall; the slowest correct run is far shorter.
    localparam int CYCLE_LIMIT = 200_000;
    // Percent of cycles in which each side idles while idling is enabled.
    localparam int IDLE_PCT = 14;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic [1:0]                i_req_type = 2'd0;
    logic [gha_pkg::IDX_W-1:0] i_handle_index = '0;
    logic [gha_pkg::GEN_W-1:0] i_handle_generation = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [1:0]                o_status;
    logic [gha_pkg::IDX_W-1:0] o_out_index;
    logic [gha_pkg::GEN_W-1:0] o_out_generation;
    logic [gha_pkg::CNT_W-1:0] o_live_count;

    generational_handle_allocator_core u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_req_type          (i_req_type),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .empty               (empty),
        .pop                 (pop),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_live_count        (o_live_count)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predicted allocator state: slot table, free-index ring, counters.
    // ------------------------------------------------------------------
    logic                      tbl_alive [gha_pkg::MAX_SLOTS];
    logic [gha_pkg::GEN_W-1:0] tbl_gen   [gha_pkg::MAX_SLOTS];
    logic [gha_pkg::IDX_W-1:0] ring_idx  [gha_pkg::MAX_SLOTS];
    int                        ring_rd, ring_wr, ring_cnt;
    int                        fresh_used;   // slots ever appended since reset or clear
    int                        live_now;     // running count of alive slots

    gha_pkg::t_rsp             pending_results [$];

    int                        error_count = 0;
    int                        results_checked = 0;
    int                        items_sent = 0;
    int                        op_seen [4];
    int                        cycle_count = 0;
    bit                        idle_on = 1'b1;
    int                        rx_hold_ask = 0;
    int                        rx_hold_len = 0;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic bit idle_now();
        return idle_on && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // A handle is good when it is not null, lies below the append mark, is alive
    // and carries the slot's current generation.
    function automatic bit handle_good(input logic [gha_pkg::IDX_W-1:0] idx,
                                       input logic [gha_pkg::GEN_W-1:0] gen);
        return gen != '0 && int'(idx) < fresh_used && tbl_alive[idx] && tbl_gen[idx] == gen;
    endfunction

    // Advance the predicted state by one accepted request and queue its result.
    task automatic predict_request(input gha_pkg::t_op op,
                                   input logic [gha_pkg::IDX_W-1:0] idx,
                                   input logic [gha_pkg::GEN_W-1:0] gen);
        gha_pkg::t_rsp             want;
        logic [gha_pkg::IDX_W-1:0] slot;
        bit                        got;
        want.status = gha_pkg::STATUS_OK;
        want.index  = '0;
        want.gen    = '0;
        want.live   = '0;
        slot        = '0;
        got         = 1'b0;
        case (op)
            gha_pkg::OP_CREATE: begin
                // Reuse the oldest freed index first, else append a fresh slot.
                if (ring_cnt > 0) begin
                    slot     = ring_idx[ring_rd];
                    ring_rd  = (ring_rd + 1) % gha_pkg::MAX_SLOTS;
                    ring_cnt--;
                    got      = 1'b1;
                end else if (fresh_used < gha_pkg::MAX_SLOTS) begin
                    slot            = gha_pkg::IDX_W'(fresh_used);
                    tbl_gen[slot]   = '0;
                    tbl_alive[slot] = 1'b0;
                    fresh_used++;
                    got             = 1'b1;
                end
                if (got) begin
                    if (!tbl_alive[slot]) live_now++;
                    tbl_alive[slot] = 1'b1;
                    // A wrapped or fresh generation of zero would be the null handle.
                    if (tbl_gen[slot] == '0) tbl_gen[slot] = gha_pkg::GEN_W'(1);
                    want.index = slot;
                    want.gen   = tbl_gen[slot];
                end else begin
                    want.status = gha_pkg::STATUS_FULL;
                end
            end
            gha_pkg::OP_DESTROY: begin
                if (handle_good(idx, gen)) begin
                    tbl_alive[idx] = 1'b0;
                    tbl_gen[idx]   = tbl_gen[idx] + 1'b1;   // wraps at the field width
                    if (live_now > 0) live_now--;
                    if (ring_cnt < gha_pkg::MAX_SLOTS) begin
                        ring_idx[ring_wr] = idx;
                        ring_wr  = (ring_wr + 1) % gha_pkg::MAX_SLOTS;
                        ring_cnt++;
                    end
                end else begin
                    want.status = gha_pkg::STATUS_INVALID;
                end
            end
            gha_pkg::OP_VALIDATE: begin
                want.status = handle_good(idx, gen) ? gha_pkg::STATUS_OK
                                                    : gha_pkg::STATUS_INVALID;
            end
            default: begin
                // Clear all: drop every slot and every queued index.
                fresh_used = 0;
                ring_rd    = 0;
                ring_wr    = 0;
                ring_cnt   = 0;
                live_now   = 0;
            end
        endcase
        want.live = gha_pkg::CNT_W'(live_now);
        pending_results = {pending_results, want};
    endtask

    // ------------------------------------------------------------------
    // Request side. Hold push high across back-to-back transfers; lower it
    // only on an idle cycle or when pausing, so push sees one update per edge.
    // ------------------------------------------------------------------
    task automatic send_request(input gha_pkg::t_op op,
                                input logic [gha_pkg::IDX_W-1:0] idx,
                                input logic [gha_pkg::GEN_W-1:0] gen);
        while (idle_now()) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push                <= 1'b1;
        i_req_type          <= op;
        i_handle_index      <= idx;
        i_handle_generation <= gen;
        @(posedge i_clk);
        // full is sampled before the edge updates it: the transfer happens here.
        while (full !== 1'b0) @(posedge i_clk);
        predict_request(op, idx, gen);
        op_seen[op]++;
        items_sent++;
    endtask

    // Pause the sender until every queued result has been checked.
    task automatic wait_all_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Pick a handle for destroy or validate: mostly a live one, sometimes a
    // stale or wrong generation, sometimes pure noise.
    task automatic pick_handle(inout logic [gha_pkg::IDX_W-1:0] idx,
                               inout logic [gha_pkg::GEN_W-1:0] gen);
        int roll;
        roll = $urandom_range(99);
        if (fresh_used == 0 || roll >= 90) return;     // keep the noise handle
        for (int k = 0; k < 8; k++) begin
            idx = gha_pkg::IDX_W'($urandom_range(fresh_used - 1));
            if (tbl_alive[idx]) break;
        end
        gen = tbl_gen[idx];
        if (roll >= 80) gen = gen + gha_pkg::GEN_W'($urandom_range(2)) - 1'b1;  // near miss
    endtask

    task automatic random_traffic(input int n);
        gha_pkg::t_op              op;
        logic [gha_pkg::IDX_W-1:0] idx;
        logic [gha_pkg::GEN_W-1:0] gen;
        int                        roll;
        repeat (n) begin
            roll = $urandom_range(99);
            idx  = gha_pkg::IDX_W'($urandom_range(gha_pkg::MAX_SLOTS - 1));
            gen  = gha_pkg::GEN_W'($urandom);
            if (roll < 42) begin
                op = gha_pkg::OP_CREATE;
            end else if (roll < 99) begin
                op = (roll < 72) ? gha_pkg::OP_DESTROY : gha_pkg::OP_VALIDATE;
                pick_handle(idx, gen);
            end else begin
                op = gha_pkg::OP_CLEAR;
            end
            send_request(op, idx, gen);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver hold-off: load a requested stretch and count it down.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_ask != 0) begin
            rx_hold_len <= rx_hold_ask;
            rx_hold_ask = 0;
        end else if (rx_hold_len > 0) begin
            rx_hold_len <= rx_hold_len - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result side: check each transfer against the oldest expectation,
    // then choose pop for the next cycle (hold-off wins over random idling).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        gha_pkg::t_rsp want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("result with nothing pending: status %0d index %0d",
                                       o_status, o_out_index));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_status !== want.status)
                    report_error($sformatf("status %h, want %0d", o_status, want.status));
                if (o_out_index !== want.index)
                    report_error($sformatf("out_index %h, want %h", o_out_index, want.index));
                if (o_out_generation !== want.gen)
                    report_error($sformatf("out_generation %h, want %h",
                                           o_out_generation, want.gen));
                if (o_live_count !== want.live)
                    report_error($sformatf("live_count %h, want %h", o_live_count, want.live));
            end
        end
        if (rx_hold_len > 0) begin
            pop <= 1'b0;
        end else begin
            pop <= !idle_now();
        end
    end

    // Watchdog: end the run if transfers stop making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk every request type through its corner cases on a tiny table.
    task automatic test_basic_ops();
        send_request(gha_pkg::OP_CLEAR, '0, '0);
        send_request(gha_pkg::OP_VALIDATE, 10'd0, 16'd1);        // nothing allocated yet
        send_request(gha_pkg::OP_DESTROY, 10'd0, 16'd1);
        send_request(gha_pkg::OP_CREATE, '0, '0);                // fresh slot 0, gen 1
        send_request(gha_pkg::OP_CREATE, '0, '0);                // fresh slot 1, gen 1
        send_request(gha_pkg::OP_VALIDATE, 10'd0, 16'd1);
        send_request(gha_pkg::OP_VALIDATE, 10'd0, 16'd0);        // null handle
        send_request(gha_pkg::OP_DESTROY, 10'd1, 16'd0);         // null handle
        send_request(gha_pkg::OP_VALIDATE, 10'd0, 16'd2);        // wrong generation
        send_request(gha_pkg::OP_VALIDATE, 10'h3FF, 16'hFFFF);   // index beyond the slots in use
        send_request(gha_pkg::OP_DESTROY, 10'd0, 16'd1);
        send_request(gha_pkg::OP_DESTROY, 10'd0, 16'd1);         // already dead
        send_request(gha_pkg::OP_VALIDATE, 10'd0, 16'd2);        // bumped but not alive
        send_request(gha_pkg::OP_CREATE, '0, '0);                // reuse slot 0, gen 2
        send_request(gha_pkg::OP_DESTROY, 10'd1, 16'd1);
        send_request(gha_pkg::OP_DESTROY, 10'd0, 16'd2);
        send_request(gha_pkg::OP_CREATE, '0, '0);                // oldest freed first: slot 1
        send_request(gha_pkg::OP_CREATE, '0, '0);                // then slot 0
        send_request(gha_pkg::OP_CREATE, '0, '0);                // ring empty: append slot 2
        send_request(gha_pkg::OP_VALIDATE, 10'd2, 16'd1);
        send_request(gha_pkg::OP_CLEAR, 10'h2AA, 16'h5555);
        send_request(gha_pkg::OP_VALIDATE, 10'd0, 16'd3);        // gone after clear
        send_request(gha_pkg::OP_CREATE, 10'h155, 16'hAAAA);
        wait_all_results();
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the result queue fills and full rises.
    task automatic test_back_pressure();
        rx_hold_ask = 400;
        idle_on = 1'b0;
        random_traffic(64);
        idle_on = 1'b1;
        wait_all_results();
    endtask

    // Random mix, with a stretch where neither side idles.
    task automatic test_random_mix();
        random_traffic(250);
        idle_on = 1'b0;
        random_traffic(200);
        idle_on = 1'b1;
        random_traffic(250);
        wait_all_results();
    endtask

    initial begin
        foreach (op_seen[k]) op_seen[k] = 0;
        foreach (tbl_alive[k]) begin
            tbl_alive[k] = 1'b0;
            tbl_gen[k]   = '0;
            ring_idx[k]  = '0;
        end
        ring_rd = 0;
        ring_wr = 0;
        ring_cnt = 0;
        fresh_used = 0;
        live_now = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_back_pressure();
        test_random_mix();

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests (%0d create, %0d destroy, %0d validate, %0d clear),",
                 items_sent, op_seen[gha_pkg::OP_CREATE], op_seen[gha_pkg::OP_DESTROY],
                 op_seen[gha_pkg::OP_VALIDATE], op_seen[gha_pkg::OP_CLEAR]);
        $display("checked %0d results across index reuse, stale handles and long stalls",
                 results_checked);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### generational_handle_allocator_core.f
design/gha_pkg.sv
design/gha_front.sv
design/gha_back.sv
design/gha_out.sv
design/generational_handle_allocator_core.sv
sim/generational_handle_allocator_core_tb.sv
